// ===== hdl/linked_block_chain_allocator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the linked block chain allocator
// Each check compiles away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef LINKED_BLOCK_CHAIN_ALLOCATOR_CORE_MACROS_SVH
`define LINKED_BLOCK_CHAIN_ALLOCATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define LBCA_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed in the same cycle");

`define LBCA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed one cycle later");

`else

`define LBCA_ASSERT_IMP(name, clk, rst, ante, cons)

`define LBCA_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/lbca_pkg.sv =====
// ----------------------------------------------------------------------------
// lbca_pkg
// Field types, result codes and the microcode program of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package lbca_pkg;

   typedef logic [1:0] status_type;
   typedef logic [3:0] block_index_type;
   typedef logic [4:0] count_type;
   typedef logic [3:0] op_type;
   typedef logic [3:0] cond_type;
   typedef logic [1:0] bsel_type;
   typedef logic [3:0] step_type;

   // Result codes.
   localparam status_type ST_ALLOCATED   = 2'd0;
   localparam status_type ST_DISK_FULL   = 2'd1;
   localparam status_type ST_ROLLED_BACK = 2'd2;
   localparam status_type ST_FREED       = 2'd3;

   // Longest chain that one request may build.
   localparam count_type MAX_CHAIN = 5'd16;

   // Datapath operations.
   localparam op_type OP_NOP        = 4'd0;
   localparam op_type OP_ACCEPT     = 4'd1;
   localparam op_type OP_TAKE       = 4'd2;
   localparam op_type OP_SEAL       = 4'd3;
   localparam op_type OP_LOAD_HEAD  = 4'd4;
   localparam op_type OP_EMIT_CHAIN = 4'd5;
   localparam op_type OP_EMIT_ONE   = 4'd6;
   localparam op_type OP_ROLLBACK   = 4'd7;
   localparam op_type OP_HEAD_LOW   = 4'd8;
   localparam op_type OP_WALK       = 4'd9;

   // Jump conditions.
   localparam cond_type C_NEVER       = 4'd0;
   localparam cond_type C_ALWAYS      = 4'd1;
   localparam cond_type C_ACCEPT      = 4'd2;
   localparam cond_type C_MODE_FREE   = 4'd3;
   localparam cond_type C_FULL        = 4'd4;
   localparam cond_type C_BIG         = 4'd5;
   localparam cond_type C_ALLOC_STOP  = 4'd6;
   localparam cond_type C_SHORT       = 4'd7;
   localparam cond_type C_EMIT_LAST   = 4'd8;
   localparam cond_type C_OUT_FREE    = 4'd9;
   localparam cond_type C_WALK_END    = 4'd10;

   // Source of block_index for single results.
   localparam bsel_type BSEL_ZERO  = 2'd0;
   localparam bsel_type BSEL_HEAD  = 2'd1;
   localparam bsel_type BSEL_START = 2'd2;

   // Program labels.
   localparam step_type S_IDLE         = 4'd0;
   localparam step_type S_DISPATCH     = 4'd1;
   localparam step_type S_CHECK_FULL   = 4'd2;
   localparam step_type S_CHECK_BIG    = 4'd3;
   localparam step_type S_ALLOC        = 4'd4;
   localparam step_type S_CHECK_SHORT  = 4'd5;
   localparam step_type S_SEAL         = 4'd6;
   localparam step_type S_LOAD_HEAD    = 4'd7;
   localparam step_type S_EMIT_CHAIN   = 4'd8;
   localparam step_type S_ROLLBACK     = 4'd9;
   localparam step_type S_REPORT_HEAD  = 4'd10;
   localparam step_type S_REPORT_FULL  = 4'd11;
   localparam step_type S_HEAD_LOW     = 4'd12;
   localparam step_type S_FREE_WALK    = 4'd13;
   localparam step_type S_REPORT_FREED = 4'd14;

   typedef struct packed {
      op_type     op;
      cond_type   cond;
      logic       stay;
      step_type   target;
      status_type sts;
      bsel_type   bsel;
   } ctrl_word_type;

   typedef struct packed {
      logic accept;
      logic mode_free;
      logic full;
      logic big;
      logic alloc_stop;
      logic short_chain;
      logic emit_last;
      logic out_free;
      logic walk_end;
   } cond_flags_type;

   function automatic ctrl_word_type ucode_word(op_type op, cond_type cond, logic stay,
                                                step_type target, status_type sts,
                                                bsel_type bsel);
      ctrl_word_type w;
      w.op     = op;
      w.cond   = cond;
      w.stay   = stay;
      w.target = target;
      w.sts    = sts;
      w.bsel   = bsel;
      return w;
   endfunction

   // The control store. A taken condition jumps to target; otherwise the
   // step either repeats (stay) or falls through to the next step.
   function automatic ctrl_word_type ucode_rom(step_type pc);
      ctrl_word_type w;
      unique case (pc)
         S_IDLE: begin
            w = ucode_word(OP_ACCEPT, C_ACCEPT, 1'b1, S_DISPATCH, ST_ALLOCATED, BSEL_ZERO);
         end
         S_DISPATCH: begin
            w = ucode_word(OP_NOP, C_MODE_FREE, 1'b0, S_FREE_WALK, ST_ALLOCATED, BSEL_ZERO);
         end
         S_CHECK_FULL: begin
            w = ucode_word(OP_NOP, C_FULL, 1'b0, S_REPORT_FULL, ST_ALLOCATED, BSEL_ZERO);
         end
         S_CHECK_BIG: begin
            w = ucode_word(OP_NOP, C_BIG, 1'b0, S_HEAD_LOW, ST_ALLOCATED, BSEL_ZERO);
         end
         S_ALLOC: begin
            w = ucode_word(OP_TAKE, C_ALLOC_STOP, 1'b1, S_CHECK_SHORT, ST_ALLOCATED,
                           BSEL_ZERO);
         end
         S_CHECK_SHORT: begin
            w = ucode_word(OP_NOP, C_SHORT, 1'b0, S_ROLLBACK, ST_ALLOCATED, BSEL_ZERO);
         end
         S_SEAL: begin
            w = ucode_word(OP_SEAL, C_NEVER, 1'b0, S_IDLE, ST_ALLOCATED, BSEL_ZERO);
         end
         S_LOAD_HEAD: begin
            w = ucode_word(OP_LOAD_HEAD, C_NEVER, 1'b0, S_IDLE, ST_ALLOCATED, BSEL_ZERO);
         end
         S_EMIT_CHAIN: begin
            w = ucode_word(OP_EMIT_CHAIN, C_EMIT_LAST, 1'b1, S_IDLE, ST_ALLOCATED, BSEL_ZERO);
         end
         S_ROLLBACK: begin
            w = ucode_word(OP_ROLLBACK, C_NEVER, 1'b0, S_IDLE, ST_ALLOCATED, BSEL_ZERO);
         end
         S_REPORT_HEAD: begin
            w = ucode_word(OP_EMIT_ONE, C_OUT_FREE, 1'b1, S_IDLE, ST_ROLLED_BACK, BSEL_HEAD);
         end
         S_REPORT_FULL: begin
            w = ucode_word(OP_EMIT_ONE, C_OUT_FREE, 1'b1, S_IDLE, ST_DISK_FULL, BSEL_ZERO);
         end
         S_HEAD_LOW: begin
            w = ucode_word(OP_HEAD_LOW, C_ALWAYS, 1'b0, S_REPORT_HEAD, ST_ALLOCATED,
                           BSEL_ZERO);
         end
         S_FREE_WALK: begin
            w = ucode_word(OP_WALK, C_WALK_END, 1'b1, S_REPORT_FREED, ST_ALLOCATED, BSEL_ZERO);
         end
         S_REPORT_FREED: begin
            w = ucode_word(OP_EMIT_ONE, C_OUT_FREE, 1'b1, S_IDLE, ST_FREED, BSEL_START);
         end
         default: begin
            w = ucode_word(OP_NOP, C_ALWAYS, 1'b0, S_IDLE, ST_ALLOCATED, BSEL_ZERO);
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/linked_block_chain_allocator_core.sv =====
// ----------------------------------------------------------------------------
// Linked block chain allocator core: one item at a time, microcoded.
// Allocate of n blocks emits a chain of n results; a free, a full disk, an
// oversized count or a rollback gives one result. The next item is accepted
// once the last result is in the output register. Reset frees every block at
// once, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linked_block_chain_allocator_core_macros.svh"

// The block keeps one allocated bit per block in flip-flops and the next-block
// links in a small RAM. A free block always reads its link as end of chain, so
// the link RAM needs no reset: its contents only matter for allocated blocks,
// and every allocated block has had its link written by the request that
// allocated it.
//
// Control is a short microprogram (see lbca_pkg). A request is accepted only in
// the idle step; the rate is set by the program: the free-block search takes
// one block per cycle, and the result walk, unless rsp_stall holds the output,
// emits one block per cycle from the registered read of the link RAM. A finished
// result waits in the output register while the sequencer idles and accepts the next item.

module linked_block_chain_allocator_core #(
   parameter int NUM_BLOCKS = 16
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_mode,
   input  lbca_pkg::count_type       req_block_count,
   input  lbca_pkg::block_index_type req_start_block,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lbca_pkg::status_type      rsp_status,
   output lbca_pkg::block_index_type rsp_block_index,
   output logic                      rsp_last
);

   import lbca_pkg::*;

   // Block indices, plus one bit in a link for the end-of-chain marker.
   localparam int IDX_W  = $clog2(NUM_BLOCKS);
   localparam int LINK_W = IDX_W + 1;
   localparam logic [LINK_W-1:0] LINK_END = '1;
   localparam logic [LINK_W-1:0] NUM_L    = LINK_W'(NUM_BLOCKS);

   ctrl_word_type  ctrl;
   cond_flags_type flags;

   // Block state.
   logic [NUM_BLOCKS-1:0] alloc_ff, alloc_in;
   logic [NUM_BLOCKS-1:0] taken_ff, taken_in;

   // Request registers.
   logic            mode_ff, mode_in;
   count_type       count_ff, count_in;
   block_index_type start_ff, start_in;

   // Chain building and walking.
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  prev_ff, prev_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] steps_ff, steps_in;
   count_type         n_ff, n_in;
   count_type         k_ff, k_in;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   status_type      rsp_status_ff, rsp_status_in;
   block_index_type rsp_block_index_ff, rsp_block_index_in;
   logic            rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              disk_full;
   logic              out_free;
   logic              alloc_stop;
   logic              walk_end;
   logic              emit_last_item;
   logic              start_in_range;
   logic [IDX_W-1:0]  low_idx;
   logic [IDX_W-1:0]  cur_idx;
   logic [LINK_W-1:0] rd_link;
   logic [LINK_W-1:0] next_link;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [LINK_W-1:0] wr_data;

   lbca_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // The read address follows the next value of the walk pointer, so the
   // registered read data always belongs to the block in cur_ff.
   lbca_ram #(
      .DATA_W (LINK_W),
      .DEPTH  (NUM_BLOCKS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cur_in[IDX_W-1:0]),
      .rd_data (rd_link)
   );

   // Lowest free block: a priority pick over the allocated bits.
   always_comb begin
      low_idx = '0;
      for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
         if (!alloc_ff[b]) begin
            low_idx = IDX_W'(b);
         end
      end
   end

   assign disk_full      = &alloc_ff;
   assign cur_idx        = cur_ff[IDX_W-1:0];
   // A free block's link is end of chain, whatever the RAM holds.
   assign next_link      = alloc_ff[cur_idx] ? rd_link : LINK_END;
   // A walk stops at an end marker (or any index past the disk) or after
   // one step per block, which bounds it even on a damaged chain.
   assign walk_end       = (cur_ff >= NUM_L) || (steps_ff == NUM_L);
   assign alloc_stop     = (n_ff == count_ff) || disk_full;
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign emit_last_item = (count_type'(k_ff + count_type'(1)) == n_ff);
   assign start_in_range = (8'(req_start_block) < 8'(NUM_BLOCKS));

   assign req_stall = (ctrl.op != OP_ACCEPT);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      flags.accept      = accept;
      flags.mode_free   = mode_ff;
      flags.full        = disk_full;
      flags.big         = (count_ff > MAX_CHAIN);
      flags.alloc_stop  = alloc_stop;
      flags.short_chain = (n_ff != count_ff);
      flags.emit_last   = out_free && emit_last_item;
      flags.out_free    = out_free;
      flags.walk_end    = walk_end;
   end

   // Datapath: one operation per step, chosen by the control word.
   always_comb begin
      alloc_in           = alloc_ff;
      taken_in           = taken_ff;
      mode_in            = mode_ff;
      count_in           = count_ff;
      start_in           = start_ff;
      head_in            = head_ff;
      prev_in            = prev_ff;
      cur_in             = cur_ff;
      steps_in           = steps_ff;
      n_in               = n_ff;
      k_in               = k_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_block_index_in = rsp_block_index_ff;
      rsp_last_in        = rsp_last_ff;
      wr_en              = 1'b0;
      wr_addr            = prev_ff;
      wr_data            = LINK_END;

      unique case (ctrl.op)
         OP_ACCEPT: begin
            if (accept) begin
               mode_in  = req_mode;
               // A count of zero still allocates one block.
               count_in = (req_block_count == '0) ? count_type'(1) : req_block_count;
               start_in = req_start_block;
               cur_in   = start_in_range ? LINK_W'(req_start_block) : LINK_END;
               steps_in = '0;
               n_in     = '0;
               k_in     = '0;
               taken_in = '0;
            end
         end
         OP_TAKE: begin
            // Take the lowest free block and hang it behind the previous one.
            if (!alloc_stop) begin
               alloc_in[low_idx] = 1'b1;
               taken_in[low_idx] = 1'b1;
               prev_in           = low_idx;
               n_in              = count_type'(n_ff + count_type'(1));
               if (n_ff == '0) begin
                  head_in = low_idx;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = prev_ff;
                  wr_data = LINK_W'(low_idx);
               end
            end
         end
         OP_SEAL: begin
            wr_en   = 1'b1;
            wr_addr = prev_ff;
            wr_data = LINK_END;
         end
         OP_LOAD_HEAD: begin
            cur_in = LINK_W'(head_ff);
            k_in   = '0;
         end
         OP_EMIT_CHAIN: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = ST_ALLOCATED;
               rsp_block_index_in = block_index_type'(cur_ff);
               rsp_last_in        = emit_last_item;
               cur_in             = next_link;
               k_in               = count_type'(k_ff + count_type'(1));
            end
         end
         OP_EMIT_ONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ctrl.sts;
               rsp_last_in   = 1'b1;
               case (ctrl.bsel)
                  BSEL_HEAD:  rsp_block_index_in = block_index_type'(head_ff);
                  BSEL_START: rsp_block_index_in = start_ff;
                  default:    rsp_block_index_in = '0;
               endcase
            end
         end
         OP_ROLLBACK: begin
            // Release every block this request took, all at once.
            alloc_in = alloc_ff & ~taken_ff;
         end
         OP_HEAD_LOW: begin
            head_in = low_idx;
         end
         OP_WALK: begin
            if (!walk_end) begin
               alloc_in[cur_idx] = 1'b0;
               cur_in            = next_link;
               steps_in          = LINK_W'(steps_ff + LINK_W'(1));
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      taken_ff           <= taken_in;
      mode_ff            <= mode_in;
      count_ff           <= count_in;
      start_ff           <= start_in;
      head_ff            <= head_in;
      prev_ff            <= prev_in;
      cur_ff             <= cur_in;
      steps_ff           <= steps_in;
      n_ff               <= n_in;
      k_ff               <= k_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_block_index_ff <= rsp_block_index_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_block_index = rsp_block_index_ff;
   assign rsp_last        = rsp_last_ff;

   // Every block sent out as part of a chain is marked allocated.
   `LBCA_ASSERT_IMP(a_emitted_block_allocated, clock, reset, (ctrl.op == OP_EMIT_CHAIN) && out_free, alloc_ff[cur_idx])

   // A rollback leaves none of the request's blocks allocated.
   `LBCA_ASSERT_NEXT(a_rollback_clears_taken, clock, reset, ctrl.op == OP_ROLLBACK, (alloc_ff & taken_ff) == '0)

   // The chain under construction never grows past the requested count.
   `LBCA_ASSERT_IMP(a_chain_within_count, clock, reset, ctrl.op == OP_TAKE, n_ff <= count_ff)

   // Failures and frees are always a single, final result.
   `LBCA_ASSERT_IMP(a_single_results_last, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_ALLOCATED), rsp_last_ff)

endmodule

`default_nettype wire

// ===== hdl/lbca_ram.sv =====
// ----------------------------------------------------------------------------
// lbca_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lbca_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/lbca_seq.sv =====
// ----------------------------------------------------------------------------
// lbca_seq
// Step counter and control store; evaluates the jump condition of each step.
// ----------------------------------------------------------------------------
`default_nettype none

module lbca_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  lbca_pkg::cond_flags_type flags,
   output lbca_pkg::ctrl_word_type  ctrl
);

   import lbca_pkg::*;

   step_type pc_ff;
   step_type pc_in;
   logic     jump;

   assign ctrl = ucode_rom(pc_ff);

   always_comb begin
      unique case (ctrl.cond)
         C_NEVER:      jump = 1'b0;
         C_ALWAYS:     jump = 1'b1;
         C_ACCEPT:     jump = flags.accept;
         C_MODE_FREE:  jump = flags.mode_free;
         C_FULL:       jump = flags.full;
         C_BIG:        jump = flags.big;
         C_ALLOC_STOP: jump = flags.alloc_stop;
         C_SHORT:      jump = flags.short_chain;
         C_EMIT_LAST:  jump = flags.emit_last;
         C_OUT_FREE:   jump = flags.out_free;
         C_WALK_END:   jump = flags.walk_end;
         default:      jump = 1'b0;
      endcase

      if (jump) begin
         pc_in = ctrl.target;
      end else if (ctrl.stay) begin
         pc_in = pc_ff;
      end else begin
         pc_in = step_type'(pc_ff + step_type'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ===== verif/tb_linked_block_chain_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_linked_block_chain_allocator_core
// Self-checking bench for the linked block chain allocator. A directed table
// covers the corner cases: reset state, zero and oversized counts, full disk,
// rollback, and frees of heads, middles and free blocks. Several hundred
// random requests follow. Every accepted request runs through a local
// allocator model, and each result leaving the block is compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_linked_block_chain_allocator_core;

   import lbca_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int NUM_BLOCKS   = 16;
   localparam int RESET_CYCLES = 12;

   // Random part. The long receiver hold, the sender drain and the quiet tail
   // are placed at fixed points of the random item count.
   localparam int RANDOM_ITEMS = 430;
   localparam int HOLD_AT      = 120;
   localparam int DRAIN_AT     = 260;
   localparam int CALM_AT      = 350;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 60;

   localparam logic       MODE_ALLOC = 1'b0;
   localparam logic       MODE_FREE  = 1'b1;
   localparam logic [4:0] LINK_NONE  = 5'h1f;

   typedef struct {
      status_type      status;
      block_index_type index;
      logic            last;
   } chain_result_type;

   // One directed request. Where typed is set, the request must give a single
   // result with the listed status and block index.
   typedef struct {
      logic            mode;
      count_type       count;
      block_index_type start;
      logic            typed;
      status_type      status;
      block_index_type index;
   } directed_row_type;

   localparam int NUM_DIRECTED = 24;

   // The table is walked from reset, so each row depends on all rows above it.
   directed_row_type directed_rows [NUM_DIRECTED] = '{
      // Count of zero takes one block; the disk starts empty.
      '{MODE_ALLOC, 5'd0,  4'd0,  1'b1, ST_ALLOCATED,   4'd0},
      '{MODE_ALLOC, 5'd1,  4'd0,  1'b1, ST_ALLOCATED,   4'd1},
      // Oversized counts fail with the lowest free block and change nothing.
      '{MODE_ALLOC, 5'd31, 4'd0,  1'b1, ST_ROLLED_BACK, 4'd2},
      '{MODE_ALLOC, 5'd17, 4'd0,  1'b1, ST_ROLLED_BACK, 4'd2},
      // Sixteen wanted, fourteen free: the partial chain is rolled back.
      '{MODE_ALLOC, 5'd16, 4'd0,  1'b1, ST_ROLLED_BACK, 4'd2},
      '{MODE_FREE,  5'd0,  4'd1,  1'b1, ST_FREED,       4'd1},
      // Fifteen blocks fill the disk exactly.
      '{MODE_ALLOC, 5'd15, 4'd0,  1'b0, ST_ALLOCATED,   4'd0},
      '{MODE_ALLOC, 5'd1,  4'd0,  1'b1, ST_DISK_FULL,   4'd0},
      '{MODE_ALLOC, 5'd31, 4'd0,  1'b1, ST_DISK_FULL,   4'd0},
      // Free from the middle of a chain, then free a block that is free.
      '{MODE_FREE,  5'd0,  4'd8,  1'b1, ST_FREED,       4'd8},
      '{MODE_FREE,  5'd0,  4'd12, 1'b1, ST_FREED,       4'd12},
      '{MODE_ALLOC, 5'd4,  4'd0,  1'b0, ST_ALLOCATED,   4'd0},
      '{MODE_FREE,  5'd0,  4'd0,  1'b1, ST_FREED,       4'd0},
      // The old chain still links into the newer one; both are released.
      '{MODE_FREE,  5'd0,  4'd1,  1'b1, ST_FREED,       4'd1},
      // Longest chain: sixteen results for one request.
      '{MODE_ALLOC, 5'd16, 4'd0,  1'b0, ST_ALLOCATED,   4'd0},
      '{MODE_ALLOC, 5'd0,  4'd0,  1'b1, ST_DISK_FULL,   4'd0},
      '{MODE_FREE,  5'd31, 4'd0,  1'b1, ST_FREED,       4'd0},
      '{MODE_FREE,  5'd0,  4'd15, 1'b1, ST_FREED,       4'd15},
      '{MODE_ALLOC, 5'd3,  4'd15, 1'b0, ST_ALLOCATED,   4'd0},
      '{MODE_ALLOC, 5'd21, 4'd0,  1'b1, ST_ROLLED_BACK, 4'd3},
      '{MODE_ALLOC, 5'd13, 4'd0,  1'b0, ST_ALLOCATED,   4'd0},
      // Free the tail of a chain, then ask for more than the one free block.
      '{MODE_FREE,  5'd0,  4'd2,  1'b1, ST_FREED,       4'd2},
      '{MODE_ALLOC, 5'd2,  4'd0,  1'b1, ST_ROLLED_BACK, 4'd2},
      '{MODE_FREE,  5'd0,  4'd3,  1'b1, ST_FREED,       4'd3}
   };

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   logic            req_mode;
   count_type       req_block_count;
   block_index_type req_start_block;
   logic            rsp_valid;
   logic            rsp_stall;
   status_type      rsp_status;
   block_index_type rsp_block_index;
   logic            rsp_last;

   // Side information that travels with the item on the request port.
   logic            item_typed;
   status_type      item_status;
   block_index_type item_index;

   // Local copy of the disk: allocated marks and next-block links.
   logic            block_taken [NUM_BLOCKS];
   logic [4:0]      block_next  [NUM_BLOCKS];

   chain_result_type chain_results_due [$];
   block_index_type  live_heads [$];

   int              errors = 0;
   bit              calm = 1'b0;
   bit              hold_rsp_req = 1'b0;

   linked_block_chain_allocator_core #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_block_count(req_block_count),
      .req_start_block(req_start_block),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_block_index(rsp_block_index),
      .rsp_last       (rsp_last)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ----------------------------------------------------------------------
   // Allocator model
   // ----------------------------------------------------------------------

   // Lowest free block, or -1 when the disk is full.
   function automatic int first_free_block();
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         if (!block_taken[b]) begin
            return b;
         end
      end
      return -1;
   endfunction

   // Follows links from a block and frees every block reached. The walk ends at
   // the end-of-chain link or after one step per block, so a broken chain can
   // never loop.
   function automatic void release_chain(int from);
      int cur;
      int nxt;
      int steps;
      cur   = from;
      steps = 0;
      while (cur < NUM_BLOCKS && steps < NUM_BLOCKS) begin
         nxt              = int'(block_next[cur]);
         block_taken[cur] = 1'b0;
         block_next[cur]  = LINK_NONE;
         cur              = nxt;
         steps++;
      end
   endfunction

   // Applies one request to the local disk and queues the results it should
   // cause. Returns how many results were queued.
   function automatic int predict_chain_results(logic mode, count_type count,
                                                block_index_type start);
      chain_result_type r;
      block_index_type  chain [$];
      int               want;
      int               head;
      int               prev;
      int               cur;
      r.last = 1'b1;
      if (mode == MODE_FREE) begin
         release_chain(int'(start));
         r.status = ST_FREED;
         r.index  = start;
         chain_results_due.push_back(r);
         return 1;
      end
      want = (count == '0) ? 1 : int'(count);
      head = first_free_block();
      if (head < 0) begin
         r.status = ST_DISK_FULL;
         r.index  = '0;
         chain_results_due.push_back(r);
         return 1;
      end
      r.status = ST_ROLLED_BACK;
      r.index  = block_index_type'(head);
      // A chain longer than the result stream can carry is refused outright.
      if (want > int'(MAX_CHAIN)) begin
         chain_results_due.push_back(r);
         return 1;
      end
      block_taken[head] = 1'b1;
      chain.push_back(block_index_type'(head));
      prev = head;
      for (int i = 1; i < want; i++) begin
         cur = first_free_block();
         if (cur < 0) begin
            // Out of blocks partway: undo what was taken and report the head.
            release_chain(head);
            chain_results_due.push_back(r);
            return 1;
         end
         block_taken[cur] = 1'b1;
         block_next[prev] = 5'(cur);
         prev             = cur;
         chain.push_back(block_index_type'(cur));
      end
      block_next[prev] = LINK_NONE;
      live_heads.push_back(block_index_type'(head));
      foreach (chain[i]) begin
         r.status = ST_ALLOCATED;
         r.index  = chain[i];
         r.last   = (i == chain.size() - 1);
         chain_results_due.push_back(r);
      end
      return chain.size();
   endfunction

   // ----------------------------------------------------------------------
   // Monitor: sees both handshakes at the rising edge. Requests are modeled
   // first, so the queue always holds the results of everything accepted.
   // ----------------------------------------------------------------------
   always @(posedge clock) begin
      chain_result_type got;
      chain_result_type want;
      int               n;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            n = predict_chain_results(req_mode, req_block_count, req_start_block);
            if (item_typed) begin
               // The table row states the outcome; it replaces the model's.
               for (int i = 0; i < n; i++) begin
                  void'(chain_results_due.pop_back());
               end
               want.status = item_status;
               want.index  = item_index;
               want.last   = 1'b1;
               chain_results_due.push_back(want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got.status = rsp_status;
            got.index  = rsp_block_index;
            got.last   = rsp_last;
            if (chain_results_due.size() == 0) begin
               $display("%0t: result with none expected: status %0d block %0d last %0b",
                        $time, got.status, got.index, got.last);
               errors++;
            end else begin
               want = chain_results_due.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, got.status);
                  errors++;
               end
               if (got.index !== want.index) begin
                  $display("%0t: block_index expected %0d, got %0d",
                           $time, want.index, got.index);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last expected %0b, got %0b", $time, want.last, got.last);
                  errors++;
               end
            end
         end
      end
   end

   // ----------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold when
   // asked for, and no stalls once the quiet tail starts.
   // ----------------------------------------------------------------------
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_req) begin
            // Long hold: the block fills up and has to stall its input.
            hold_rsp_req = 1'b0;
            rsp_stall    = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(0, 5)) @(negedge clock);
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // ----------------------------------------------------------------------
   // Sender
   // ----------------------------------------------------------------------

   // Moves to the next falling edge and, at random, first holds valid low for a burst.
   task automatic sender_gap();
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   // Offers one item and returns at the rising edge where it is taken. The
   // payload stays put while the block stalls it.
   task automatic offer_request(logic mode, count_type count, block_index_type start,
                                logic typed, status_type status, block_index_type index);
      req_valid       = 1'b1;
      req_mode        = mode;
      req_block_count = count;
      req_start_block = start;
      item_typed      = typed;
      item_status     = status;
      item_index      = index;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drops valid and waits for every outstanding result.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (chain_results_due.size() != 0) @(negedge clock);
   endtask

   initial begin
      logic            mode;
      count_type       count;
      block_index_type start;
      int              pick;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = MODE_ALLOC;
      req_block_count = '0;
      req_start_block = '0;
      item_typed      = 1'b0;
      item_status     = ST_ALLOCATED;
      item_index      = '0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         block_taken[b] = 1'b0;
         block_next[b]  = LINK_NONE;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         sender_gap();
         offer_request(directed_rows[i].mode, directed_rows[i].count,
                       directed_rows[i].start, directed_rows[i].typed,
                       directed_rows[i].status, directed_rows[i].index);
      end

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == HOLD_AT) begin
            hold_rsp_req = 1'b1;
         end
         if (k == DRAIN_AT) begin
            drain_results();
         end
         if (k == CALM_AT) begin
            calm = 1'b1;
         end
         sender_gap();
         // Fields are picked after the falling edge, once the monitor has
         // recorded the chains made by earlier requests.
         if ($urandom_range(0, 99) < 55) begin
            mode = MODE_ALLOC;
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               count = count_type'($urandom_range(0, 4));
            end else if (pick < 8) begin
               count = count_type'($urandom_range(5, 15));
            end else if (pick < 9) begin
               count = MAX_CHAIN;
            end else begin
               count = count_type'($urandom_range(17, 31));
            end
            start = block_index_type'($urandom_range(0, 15));
         end else begin
            mode  = MODE_FREE;
            count = count_type'($urandom_range(0, 31));
            // Mostly heads of real chains; the rest hit middles and free blocks.
            if (live_heads.size() != 0 && $urandom_range(0, 3) != 0) begin
               pick  = $urandom_range(0, live_heads.size() - 1);
               start = live_heads[pick];
               live_heads.delete(pick);
            end else begin
               start = block_index_type'($urandom_range(0, 15));
            end
         end
         offer_request(mode, count, start, 1'b0, ST_ALLOCATED, '0);
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("tb_linked_block_chain_allocator_core: PASS");
      end else begin
         $display("tb_linked_block_chain_allocator_core: FAIL");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #(CLOCK_PERIOD * 400000);
      $display("tb_linked_block_chain_allocator_core: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
